@@ hw/rtl/i2cbr_pkg.sv @@
`default_nettype none

package i2cbr_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_CLOCKS  = 2'd0;
  localparam logic [1:0] REG_HALF_PERIOD = 2'd1;
  localparam logic [1:0] REG_SETTLE      = 2'd2;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  // Reset values of the configuration registers
  localparam logic [3:0] MAX_CLOCKS_RST  = 4'd9;
  localparam logic [7:0] HALF_PERIOD_RST = 8'd1;
  localparam logic [7:0] SETTLE_RST      = 8'd1;

  typedef struct packed {
    logic [3:0] max_clocks;
    logic [7:0] half_period_ticks;
    logic [7:0] settle_ticks;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [3:0] clocks_sent;
    logic       bus_error;
    logic       done_res;
    logic       busy_res;
    logic       pins_taken;
    logic       sda_release;
    logic       scl_release;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/i2c_bus_recovery_sequencer.sv @@
`default_nettype none

// I2C bus-clear sequencer, one result per tick item.
// The result is registered and is valid in the cycle after the input transfer.
// Throughput: one item per cycle; the output register refills in the cycle
// it is drained, so rate is set only by the downstream tready.
// Reset (rst_n low, synchronous): idle, counters and outcome cleared,
// registers back to max_clocks 9, half period 1, settle 1.
module i2c_bus_recovery_sequencer
  import i2cbr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [7:0]            in_tdata,   // [0] scl_level, [1] sda_level
  input  wire logic                  in_tuser,   // [0] command
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // [0] scl_release, [1] sda_release, [2] pins_taken, [3] busy_res,
  // [4] done_res, [5] bus_error, [9:6] clocks_sent
  output      logic [15:0]           out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic accept;

  i2cbr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Accept when the output slot is free or drains this cycle
  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;

  i2cbr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (accept),
    .command   (in_tuser),
    .scl_level (in_tdata[0]),
    .sda_level (in_tdata[1]),
    .cfg       (cfg),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r};

endmodule

`default_nettype wire

@@ hw/rtl/i2cbr_cfg.sv @@
`default_nettype none

module i2cbr_cfg
  import i2cbr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output      cfg_t                  cfg
);

  cfg_t cfg_r;

  // Register file, write only; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_clocks        <= MAX_CLOCKS_RST;
      cfg_r.half_period_ticks <= HALF_PERIOD_RST;
      cfg_r.settle_ticks      <= SETTLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAX_CLOCKS:  cfg_r.max_clocks        <= cfg_wdata[3:0];
        REG_HALF_PERIOD: cfg_r.half_period_ticks <= cfg_wdata;
        REG_SETTLE:      cfg_r.settle_ticks      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ hw/rtl/i2cbr_core.sv @@
`default_nettype none

module i2cbr_core
  import i2cbr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic advance,
  input  wire logic command,
  input  wire logic scl_level,
  input  wire logic sda_level,
  input  wire cfg_t cfg,
  output      res_t res
);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SETTLE    = 3'd1;
  localparam logic [2:0] PH_CLK_LOW   = 3'd2;
  localparam logic [2:0] PH_CLK_HIGH  = 3'd3;
  localparam logic [2:0] PH_PRE_STOP  = 3'd4;
  localparam logic [2:0] PH_STOP_LOW  = 3'd5;
  localparam logic [2:0] PH_STOP_HIGH = 3'd6;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic [3:0] pulse_r, pulse_nxt;
  logic       err_r, err_nxt;
  logic [3:0] last_r, last_nxt;
  logic       done;
  logic [7:0] settle_load, half_load;
  logic [3:0] pulse_inc;

  // A wait of n ticks loads n-1; zero acts as one
  assign settle_load = (cfg.settle_ticks == 8'd0) ? 8'd0 : cfg.settle_ticks - 8'd1;
  assign half_load   = (cfg.half_period_ticks == 8'd0) ? 8'd0
                                                       : cfg.half_period_ticks - 8'd1;
  assign pulse_inc   = pulse_r + 4'd1;

  // Next state for one tick or start item
  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    pulse_nxt = pulse_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    done      = 1'b0;
    if (phase_r == PH_IDLE || phase_r > PH_STOP_HIGH) begin
      phase_nxt = PH_IDLE;
      if (command) begin
        pulse_nxt = 4'd0;
        phase_nxt = PH_SETTLE;
        wait_nxt  = settle_load;
      end
    end else if (wait_r != 8'd0) begin
      wait_nxt = wait_r - 8'd1;
    end else begin
      unique case (phase_r)
        PH_SETTLE: begin
          if ((scl_level && sda_level) || cfg.max_clocks == 4'd0) begin
            phase_nxt = PH_PRE_STOP;
            wait_nxt  = settle_load;
          end else begin
            phase_nxt = PH_CLK_LOW;
            wait_nxt  = half_load;
          end
        end
        PH_CLK_LOW: begin
          phase_nxt = PH_CLK_HIGH;
          wait_nxt  = half_load;
        end
        PH_CLK_HIGH: begin
          pulse_nxt = pulse_inc;
          if (sda_level || pulse_inc >= cfg.max_clocks) begin
            phase_nxt = PH_PRE_STOP;
            wait_nxt  = settle_load;
          end else begin
            phase_nxt = PH_CLK_LOW;
            wait_nxt  = half_load;
          end
        end
        PH_PRE_STOP: begin
          phase_nxt = PH_STOP_LOW;
          wait_nxt  = settle_load;
        end
        PH_STOP_LOW: begin
          phase_nxt = PH_STOP_HIGH;
          wait_nxt  = settle_load;
        end
        default: begin
          // end of STOP: check the bus and report
          err_nxt   = ~(scl_level & sda_level);
          last_nxt  = pulse_r;
          phase_nxt = PH_IDLE;
          wait_nxt  = 8'd0;
          done      = 1'b1;
        end
      endcase
    end
  end

  // State registers move only on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_r  <= 8'd0;
      pulse_r <= 4'd0;
      err_r   <= 1'b0;
      last_r  <= 4'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      pulse_r <= pulse_nxt;
      err_r   <= err_nxt;
      last_r  <= last_nxt;
    end
  end

  // Result from the state after this item
  always_comb begin
    res.scl_release = (phase_nxt != PH_CLK_LOW);
    res.sda_release = (phase_nxt != PH_STOP_LOW);
    res.pins_taken  = (phase_nxt != PH_IDLE);
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.done_res    = done;
    res.bus_error   = err_nxt;
    res.clocks_sent = last_nxt;
  end

endmodule

`default_nettype wire
